FILE: rtl/core/pteb_pkg.sv
`default_nettype none

package pteb_pkg;

  localparam int NUM_CHANNELS = 8;
  localparam int ADDR_CHANNELS = 8;
  localparam int NUM_STORED = (NUM_CHANNELS < ADDR_CHANNELS) ? NUM_CHANNELS : ADDR_CHANNELS;
  localparam int IDX_W = (NUM_STORED > 1) ? $clog2(NUM_STORED) : 1;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    MODE_TICK   = 2'd0,
    MODE_ARM    = 2'd1,
    MODE_DISARM = 2'd2,
    MODE_NONE   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    KIND_ARM    = 2'd0,
    KIND_DISARM = 2'd1,
    KIND_EXPIRY = 2'd2,
    KIND_IDLE   = 2'd3
  } kind_e;

  typedef struct packed {
    mode_e       op;
    logic [2:0]  channel;
    logic        in_range;
    logic [31:0] count;
    logic [31:0] reload;
  } cmd_t;

  typedef struct packed {
    kind_e      kind;
    logic [2:0] which;
    logic       was_armed;
    logic       last;
  } res_t;

endpackage

`default_nettype wire

FILE: rtl/core/periodic_timer_event_bank_unit.sv
// Bank of countdown timers with reload. Arm and disarm beats are handled in the
// execution unit and give one result each; a tick beat walks the channels one per
// cycle from the highest index down, pausing while a result is due and the output
// register is held; the unit takes no other command until the walk ends. Expiry
// results come out highest channel first, with last set on the final one; a tick
// with no expiry answers once with kind 3. A two-entry command queue lets input
// beats be taken while a tick is still being walked.
`default_nettype none

module periodic_timer_event_bank_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  mode_i,
  input  wire logic [2:0]  channel_i,
  input  wire logic [31:0] count_i,
  input  wire logic [31:0] reload_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       kind_o,
  output logic [2:0]       which_o,
  output logic             was_armed_o,
  output logic             last_o
);
  import pteb_pkg::*;

  logic push_valid, push_ready;
  cmd_t push_cmd;
  logic pop_valid, pop_ready;
  cmd_t pop_cmd;
  res_t res;

  pteb_front u_front (
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .mode_i       (mode_i),
    .channel_i    (channel_i),
    .count_i      (count_i),
    .reload_i     (reload_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_cmd_o   (push_cmd)
  );

  pteb_cmd_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_cmd_i   (push_cmd),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_cmd_o    (pop_cmd)
  );

  pteb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (pop_valid),
    .cmd_ready_o (pop_ready),
    .cmd_i       (pop_cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res)
  );

  assign kind_o      = res.kind;
  assign which_o     = res.which;
  assign was_armed_o = res.was_armed;
  assign last_o      = res.last;

endmodule

`default_nettype wire

FILE: rtl/core/pteb_front.sv
`default_nettype none

module pteb_front (
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  input  wire logic [1:0]   mode_i,
  input  wire logic [2:0]   channel_i,
  input  wire logic [31:0]  count_i,
  input  wire logic [31:0]  reload_i,
  output logic              push_valid_o,
  input  wire logic         push_ready_i,
  output pteb_pkg::cmd_t    push_cmd_o
);
  import pteb_pkg::*;

  mode_e mode;

  assign mode = mode_e'(mode_i);

  always_comb begin
    push_cmd_o.op       = mode;
    push_cmd_o.channel  = channel_i;
    push_cmd_o.in_range = (32'(channel_i) < 32'(NUM_CHANNELS));
    push_cmd_o.count    = count_i;
    push_cmd_o.reload   = reload_i;
    case (mode)
      MODE_TICK, MODE_ARM, MODE_DISARM: push_valid_o = in_valid_i;
      default:                          push_valid_o = 1'b0;
    endcase
  end

  // unused mode: accept the beat and drop it
  assign in_ready_o = push_ready_i;

endmodule

`default_nettype wire

FILE: rtl/core/pteb_cmd_fifo.sv
`default_nettype none

module pteb_cmd_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_valid_i,
  output logic               push_ready_o,
  input  wire pteb_pkg::cmd_t push_cmd_i,
  output logic               pop_valid_o,
  input  wire logic          pop_ready_i,
  output pteb_pkg::cmd_t     pop_cmd_o
);
  import pteb_pkg::*;

  cmd_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign push_ready_o = (cnt_q != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_cmd_o    = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/pteb_back.sv
`default_nettype none

module pteb_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           cmd_valid_i,
  output logic                cmd_ready_o,
  input  wire pteb_pkg::cmd_t cmd_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output pteb_pkg::res_t      res_o
);
  import pteb_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_e;

  state_e           state_q, state_d;
  logic [31:0]      cnt_q [NUM_STORED];
  logic [31:0]      cnt_d [NUM_STORED];
  logic [31:0]      int_q [NUM_STORED];
  logic [31:0]      int_d [NUM_STORED];
  logic [NUM_STORED-1:0] hit_q, hit_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             out_valid_q, out_valid_d;
  res_t             res_q, res_d;
  logic             emit;
  logic             can_emit;
  logic             need_emit;
  logic             lower_hit;
  logic [IDX_W-1:0] sel;

  assign can_emit = !out_valid_q || out_ready_i;
  assign sel      = cmd_i.channel[IDX_W-1:0];

  always_comb begin
    lower_hit = 1'b0;
    for (int j = 0; j < NUM_STORED; j++) begin
      if (IDX_W'(j) < idx_q) begin
        lower_hit = lower_hit | hit_q[j];
      end
    end
  end

  assign need_emit = hit_q[idx_q] || ((idx_q == '0) && (hit_q == '0));

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    int_d       = int_q;
    hit_d       = hit_q;
    idx_d       = idx_q;
    cmd_ready_o = 1'b0;
    emit        = 1'b0;
    res_d       = res_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          case (cmd_i.op)
            MODE_ARM: begin
              if (can_emit) begin
                cmd_ready_o = 1'b1;
                emit        = 1'b1;
                res_d       = '{kind: KIND_ARM, which: cmd_i.channel,
                                was_armed: 1'b0, last: 1'b1};
                if (cmd_i.in_range) begin
                  cnt_d[sel] = cmd_i.count;
                  int_d[sel] = cmd_i.reload;
                end
              end
            end
            MODE_DISARM: begin
              if (can_emit) begin
                cmd_ready_o = 1'b1;
                emit        = 1'b1;
                res_d       = '{kind: KIND_DISARM, which: cmd_i.channel,
                                was_armed: cmd_i.in_range && (cnt_q[sel] != 32'd0),
                                last: 1'b1};
                if (cmd_i.in_range) begin
                  cnt_d[sel] = 32'd0;
                  int_d[sel] = 32'd0;
                end
              end
            end
            MODE_TICK: begin
              cmd_ready_o = 1'b1;
              for (int i = 0; i < NUM_STORED; i++) begin
                hit_d[i] = (cnt_q[i] == 32'd1);
              end
              idx_d   = IDX_W'(NUM_STORED - 1);
              state_d = ST_SCAN;
            end
            default: begin
              cmd_ready_o = 1'b1;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (!need_emit || can_emit) begin
          if (hit_q[idx_q]) begin
            cnt_d[idx_q] = int_q[idx_q];
            emit         = 1'b1;
            res_d        = '{kind: KIND_EXPIRY, which: 3'(idx_q),
                             was_armed: 1'b0, last: !lower_hit};
          end else if (cnt_q[idx_q] != 32'd0) begin
            cnt_d[idx_q] = cnt_q[idx_q] - 32'd1;
          end
          if (idx_q == '0) begin
            state_d = ST_IDLE;
            if (hit_q == '0) begin
              emit  = 1'b1;
              res_d = '{kind: KIND_IDLE, which: 3'd0, was_armed: 1'b0, last: 1'b1};
            end
          end else begin
            idx_d = idx_q - 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    out_valid_d = emit ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      hit_q       <= '0;
      idx_q       <= '0;
      for (int i = 0; i < NUM_STORED; i++) begin
        cnt_q[i] <= 32'd0;
        int_q[i] <= 32'd0;
      end
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      hit_q       <= hit_d;
      idx_q       <= idx_d;
      cnt_q       <= cnt_d;
      int_q       <= int_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

FILE: rtl/core/pteb_checker.sv
`default_nettype none

module pteb_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic [1:0] kind_i,
  input wire logic [2:0] which_i,
  input wire logic       was_armed_i,
  input wire logic       last_i
);
  import pteb_pkg::*;

  // hold a stalled result beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(kind_i) && $stable(which_i)
      && $stable(was_armed_i) && $stable(last_i))
    else $error("stalled result beat changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (kind_i == KIND_IDLE) |-> last_i && (which_i == 3'd0) && !was_armed_i)
    else $error("idle tick result malformed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && was_armed_i |-> (kind_i == KIND_DISARM))
    else $error("armed flag outside disarm result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && ((kind_i == KIND_ARM) || (kind_i == KIND_DISARM)) |-> last_i)
    else $error("single result without last");

endmodule

bind periodic_timer_event_bank_unit pteb_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .kind_i      (kind_o),
  .which_i     (which_o),
  .was_armed_i (was_armed_o),
  .last_i      (last_o)
);

`default_nettype wire
